// ===== design/asp_pkg.sv =====
// shared types and constants of the accelerometer swing peak detector
`default_nettype none

package asp_pkg;

  localparam int REG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_START_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_THRESHOLD    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FULL_POWER_LEVEL = 2'd2;

  // reset values, 1/2048 g per step
  localparam logic [REG_BITS-1:0] START_THRESHOLD_RESET  = 16'd4096;
  localparam logic [REG_BITS-1:0] END_THRESHOLD_RESET    = 16'd3072;
  localparam logic [REG_BITS-1:0] FULL_POWER_LEVEL_RESET = 16'd10240;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic square;
    logic root;
    logic decide;
    logic divide;
    logic emit;
  } asp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic out_busy;
  } asp_status_t;

endpackage

`default_nettype wire

// ===== design/asp_ctrl.sv =====
// sequencing state machine of the swing peak detector
`default_nettype none

module asp_ctrl
  import asp_pkg::*;
#(
  parameter int SAMPLE_BITS         = 16,
  parameter int POWER_FRACTION_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  output logic             s_ready_o,
  input  asp_status_t      status_i,
  output asp_cmd_t         cmd_o
);

  localparam int MaxSteps = (SAMPLE_BITS > POWER_FRACTION_BITS) ? SAMPLE_BITS
                                                                 : POWER_FRACTION_BITS;
  localparam int CntW     = $clog2(MaxSteps);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DECIDE,
    ST_DIVIDE,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = ST_SQUARE;
          cnt_d   = CntW'(2);
        end
      end
      ST_SQUARE: begin
        if (cnt_q == '0) begin
          state_d = ST_ROOT;
          cnt_d   = CntW'(SAMPLE_BITS - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_q == '0) begin
          state_d = ST_DECIDE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DECIDE: begin
        if (status_i.need_div) begin
          state_d = ST_DIVIDE;
          cnt_d   = CntW'(POWER_FRACTION_BITS - 1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.square = (state_q == ST_SQUARE);
    cmd_o.root   = (state_q == ST_ROOT);
    cmd_o.decide = (state_q == ST_DECIDE);
    cmd_o.divide = (state_q == ST_DIVIDE);
    cmd_o.emit   = (state_q == ST_EMIT) && !status_i.out_busy;
  end

endmodule

`default_nettype wire

// ===== design/asp_datapath.sv =====
// squarer, square root, swing tracking, power divider and output register
`default_nettype none

module asp_datapath
  import asp_pkg::*;
#(
  parameter int SAMPLE_BITS         = 16,
  parameter int POWER_FRACTION_BITS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  asp_cmd_t                          cmd_i,
  output asp_status_t                       status_o,
  input  wire logic [SAMPLE_BITS-1:0]       accel_x_i,
  input  wire logic [SAMPLE_BITS-1:0]       accel_y_i,
  input  wire logic [SAMPLE_BITS-1:0]       accel_z_i,
  input  wire logic [REG_BITS-1:0]          start_threshold_i,
  input  wire logic [REG_BITS-1:0]          end_threshold_i,
  input  wire logic [REG_BITS-1:0]          full_power_level_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              swing_done_o,
  output logic [POWER_FRACTION_BITS:0]      swing_power_o
);

  localparam int SqW  = 2 * SAMPLE_BITS;
  localparam int RemW = SAMPLE_BITS + 3;
  localparam int CmpW = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;
  localparam int PowW = POWER_FRACTION_BITS + 1;
  localparam logic [PowW-1:0] PowerFull = {1'b1, {POWER_FRACTION_BITS{1'b0}}};

  function automatic logic [SAMPLE_BITS-1:0] abs_f(input logic [SAMPLE_BITS-1:0] v);
    return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic [SAMPLE_BITS-1:0] ax_q, ay_q, az_q;
  logic [SqW-1:0]         acc_q;
  logic [RemW-1:0]        rem_q;
  logic [SAMPLE_BITS-1:0] root_q;
  logic                   in_swing_q;
  logic [SAMPLE_BITS-1:0] peak_q;
  logic                   done_q;
  logic [PowW-1:0]        power_q;
  logic [REG_BITS-1:0]    div_rem_q;
  logic                   out_valid_q;
  logic                   out_done_q;
  logic [PowW-1:0]        out_power_q;

  // square of the axis at the head of the shift line
  logic [SqW-1:0] sq;
  assign sq = SqW'(ax_q) * SqW'(ax_q);

  // one root bit per step, two radicand bits shifted in
  logic [RemW-1:0] rem_shift, trial;
  logic            root_fit;
  assign rem_shift = {rem_q[RemW-3:0], acc_q[SqW-1 -: 2]};
  assign trial     = RemW'({root_q, 2'b01});
  assign root_fit  = rem_shift >= trial;

  // swing decision on the finished magnitude
  logic [CmpW-1:0]        mag_c, peak_c, start_c, end_c, full_c, newpeak_c;
  logic                   swing_d, dec_done, need_div;
  logic [SAMPLE_BITS-1:0] peak_d;
  logic [PowW-1:0]        dec_power;
  logic [REG_BITS-1:0]    div_num;

  assign mag_c   = CmpW'(root_q);
  assign peak_c  = CmpW'(peak_q);
  assign start_c = CmpW'(start_threshold_i);
  assign end_c   = CmpW'(end_threshold_i);
  assign full_c  = CmpW'(full_power_level_i);
  assign newpeak_c = (mag_c > peak_c) ? mag_c : peak_c;
  assign div_num   = REG_BITS'(newpeak_c - start_c);

  always_comb begin
    swing_d   = in_swing_q;
    peak_d    = peak_q;
    dec_done  = 1'b0;
    dec_power = '0;
    need_div  = 1'b0;
    if (!in_swing_q) begin
      if (mag_c > start_c) begin
        swing_d = 1'b1;
        peak_d  = root_q;
      end
    end else begin
      peak_d = SAMPLE_BITS'(newpeak_c);
      if (mag_c < end_c) begin
        swing_d  = 1'b0;
        dec_done = 1'b1;
        if (full_c <= start_c) begin
          dec_power = PowerFull;
        end else if (newpeak_c <= start_c) begin
          dec_power = '0;
        end else if (newpeak_c >= full_c) begin
          dec_power = PowerFull;
        end else begin
          // quotient stays below full scale here
          need_div = 1'b1;
        end
      end
    end
  end

  // restoring divider, remainder always below the divisor
  logic [REG_BITS:0] div_shift, den;
  logic              div_fit;
  assign div_shift = {div_rem_q, 1'b0};
  assign den       = {1'b0, full_power_level_i - start_threshold_i};
  assign div_fit   = div_shift >= den;

  assign status_o.need_div = need_div;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_swing_q  <= 1'b0;
      peak_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decide) begin
        in_swing_q <= swing_d;
        peak_q     <= peak_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= abs_f(accel_x_i);
      ay_q   <= abs_f(accel_y_i);
      az_q   <= abs_f(accel_z_i);
      acc_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.square) begin
      acc_q <= acc_q + sq;
      ax_q  <= ay_q;
      ay_q  <= az_q;
    end
    if (cmd_i.root) begin
      acc_q <= {acc_q[SqW-3:0], 2'b00};
      if (root_fit) begin
        rem_q  <= rem_shift - trial;
        root_q <= {root_q[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        root_q <= {root_q[SAMPLE_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.decide) begin
      done_q    <= dec_done;
      power_q   <= dec_power;
      div_rem_q <= div_num;
    end
    if (cmd_i.divide) begin
      if (div_fit) begin
        div_rem_q <= REG_BITS'(div_shift - den);
        power_q   <= {power_q[PowW-2:0], 1'b1};
      end else begin
        div_rem_q <= div_shift[REG_BITS-1:0];
        power_q   <= {power_q[PowW-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      out_done_q  <= done_q;
      out_power_q <= power_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign swing_done_o  = out_done_q;
  assign swing_power_o = out_power_q;

endmodule

`default_nettype wire

// ===== design/accel_swing_peak_detector.sv =====
// Accelerometer swing peak detector, top level.
//
// Slave stream takes one x/y/z sample (two's complement, 1/2048 g) per
// transaction. Master stream returns exactly one result per sample:
// tuser carries swing_done, tdata carries swing_power (full scale
// 2^POWER_FRACTION_BITS, zero when no swing ended).
// The write port sets start_threshold (0), end_threshold (1) and
// full_power_level (2); other indexes are dropped.
//
// One sample at a time: the shared squarer for the three axes, the bit-serial
// square root, a decision step, the restoring divider when a swing ends with
// a peak between the thresholds, then the output register. Once the result
// is in the output register, the block is idle and takes a new sample.
// A stalled result waits in the output register while the next sample is
// already taken and worked on; that sample then holds until the register
// frees. Reset leaves the block idle, out of a swing, with default thresholds.
`default_nettype none

module accel_swing_peak_detector
  import asp_pkg::*;
#(
  parameter int SAMPLE_BITS         = 16,
  parameter int POWER_FRACTION_BITS = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        s_axis_tvalid_i,
  output logic                                             s_axis_tready_o,
  // accel_x, accel_y, accel_z from bit 0 up
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata_i,
  output logic                                             m_axis_tvalid_o,
  input  wire logic                                        m_axis_tready_i,
  // swing_power
  output logic [((POWER_FRACTION_BITS+8)/8)*8-1:0]         m_axis_tdata_o,
  // swing_done
  output logic                                             m_axis_tuser_o,
  input  wire logic                                        cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]                     cfg_idx_i,
  input  wire logic [REG_BITS-1:0]                         cfg_data_i
);

  localparam int OutW = ((POWER_FRACTION_BITS + 8) / 8) * 8;

  logic [REG_BITS-1:0] start_threshold_q, end_threshold_q, full_power_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_threshold_q  <= START_THRESHOLD_RESET;
      end_threshold_q    <= END_THRESHOLD_RESET;
      full_power_level_q <= FULL_POWER_LEVEL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_THRESHOLD:  start_threshold_q  <= cfg_data_i;
        REG_END_THRESHOLD:    end_threshold_q    <= cfg_data_i;
        REG_FULL_POWER_LEVEL: full_power_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  asp_cmd_t                      cmd;
  asp_status_t                   status;
  logic [POWER_FRACTION_BITS:0]  swing_power;

  asp_ctrl #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .POWER_FRACTION_BITS(POWER_FRACTION_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  asp_datapath #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .POWER_FRACTION_BITS(POWER_FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .accel_x_i         (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .accel_y_i         (s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .accel_z_i         (s_axis_tdata_i[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
    .start_threshold_i (start_threshold_q),
    .end_threshold_i   (end_threshold_q),
    .full_power_level_i(full_power_level_q),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .swing_done_o      (m_axis_tuser_o),
    .swing_power_o     (swing_power)
  );

  assign m_axis_tdata_o = OutW'(swing_power);

endmodule

`default_nettype wire

// ===== design/asp_checker.sv =====
// port-level assertions for the swing peak detector, bound to the top level
`default_nettype none

module asp_checker #(
  parameter int POWER_FRACTION_BITS = 8
) (
  input wire logic                                        clk_i,
  input wire logic                                        rst_ni,
  input wire logic                                        s_axis_tvalid_i,
  input wire logic                                        s_axis_tready_o,
  input wire logic                                        m_axis_tvalid_o,
  input wire logic                                        m_axis_tready_i,
  input wire logic [((POWER_FRACTION_BITS+8)/8)*8-1:0]    m_axis_tdata_o,
  input wire logic                                        m_axis_tuser_o
);

  localparam int OutW = ((POWER_FRACTION_BITS + 8) / 8) * 8;
  localparam logic [OutW-1:0] PowerFull = OutW'(1) << POWER_FRACTION_BITS;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // no power without an ended swing
  a_power_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("power reported without swing end");

  // power never beyond full scale
  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o <= PowerFull)
    else $error("power above full scale");

  // a sample closes the input once it is accepted
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input reopened right after a transaction");

endmodule

bind accel_swing_peak_detector asp_checker #(
  .POWER_FRACTION_BITS(POWER_FRACTION_BITS)
) u_asp_checker (.*);

`default_nettype wire
